// File: rtl/core/iot_pkg.sv
package iot_pkg;

    // Size defaults for the frame store
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Register widths fixed by the register map
    localparam int DIM_W  = 9;
    localparam int MODE_W = 3;
    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;

    // APB port geometry
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Transform modes
    localparam logic [MODE_W-1:0] MODE_NEGATE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP_V   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_CW   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_CCW  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROT_180  = 3'd5;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Classified command from the front end
    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  pixel;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic              negate;
        logic              row_end;
        logic              frame_end;
    } cmd_t;

    // Finished result word
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              row_end;
        logic              frame_end;
    } res_t;

endpackage

// File: rtl/core/iot_queue.sv
module iot_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = iot_pkg::CMD_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [WIDTH-1:0]               push_data,
    output logic                           full,
    input  logic                           pop,
    output logic [WIDTH-1:0]               pop_data,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers with wrap at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/iot_front.sv
module iot_front #(
    parameter int MAX_WIDTH  = iot_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iot_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iot_pkg::PADDR_W-1:0]   paddr,
    input  logic [iot_pkg::PDATA_W-1:0]   pwdata,
    output logic [iot_pkg::PDATA_W-1:0]   prdata,
    input  logic                          accept,
    input  logic                          req_type,
    input  logic [iot_pkg::CHAN_W-1:0]    in_blue,
    input  logic [iot_pkg::CHAN_W-1:0]    in_green,
    input  logic [iot_pkg::CHAN_W-1:0]    in_red,
    output logic                          cmd_push,
    output iot_pkg::cmd_t                 cmd,
    output logic [iot_pkg::DIM_W-1:0]     width
);

    localparam int DIM_W = iot_pkg::DIM_W;
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'((MAX_WIDTH  < 256) ? MAX_WIDTH  : 256);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = DIM_W'(1);
        end
        else if (32'(v) > maxv)
        begin
            res = DIM_W'(maxv);
        end
        return res;
    endfunction

    logic [iot_pkg::MODE_W-1:0] mode_reg;
    logic [iot_pkg::MODE_W-1:0] mode_next;
    logic [DIM_W-1:0]           width_reg;
    logic [DIM_W-1:0]           width_next;
    logic [DIM_W-1:0]           height_reg;
    logic [DIM_W-1:0]           height_next;
    logic [DIM_W-1:0]           load_row_reg;
    logic [DIM_W-1:0]           load_row_next;
    logic [DIM_W-1:0]           load_col_reg;
    logic [DIM_W-1:0]           load_col_next;
    logic                       ready_reg;
    logic                       ready_next;
    logic [DIM_W-1:0]           out_row_reg;
    logic [DIM_W-1:0]           out_row_next;
    logic [DIM_W-1:0]           out_col_reg;
    logic [DIM_W-1:0]           out_col_next;

    logic                         cfg_wr;
    logic [iot_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]             w_m1;
    logic [DIM_W-1:0]             h_m1;
    logic                         swap;
    logic [DIM_W-1:0]             ow_m1;
    logic [DIM_W-1:0]             oh_m1;
    logic                         rend;
    logic                         fend;
    logic [DIM_W-1:0]             src_row;
    logic [DIM_W-1:0]             src_col;
    logic                         load_last_col;
    logic                         load_last;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[iot_pkg::REG_IDX_W+1:2];
    assign width   = width_reg;

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            iot_pkg::REG_MODE:   prdata = iot_pkg::PDATA_W'(mode_reg);
            iot_pkg::REG_WIDTH:  prdata = iot_pkg::PDATA_W'(width_reg);
            iot_pkg::REG_HEIGHT: prdata = iot_pkg::PDATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // Output geometry and end marks
    assign w_m1  = width_reg - 1'b1;
    assign h_m1  = height_reg - 1'b1;
    assign swap  = (mode_reg == iot_pkg::MODE_ROT_CW) || (mode_reg == iot_pkg::MODE_ROT_CCW);
    assign ow_m1 = swap ? h_m1 : w_m1;
    assign oh_m1 = swap ? w_m1 : h_m1;
    assign rend  = (out_col_reg == ow_m1);
    assign fend  = rend && (out_row_reg == oh_m1);

    // Map output position to source position
    always_comb
    begin
        unique case (mode_reg)
            iot_pkg::MODE_MIRROR_H:
            begin
                src_row = out_row_reg;
                src_col = w_m1 - out_col_reg;
            end
            iot_pkg::MODE_FLIP_V:
            begin
                src_row = h_m1 - out_row_reg;
                src_col = out_col_reg;
            end
            iot_pkg::MODE_ROT_CW:
            begin
                src_row = h_m1 - out_col_reg;
                src_col = out_row_reg;
            end
            iot_pkg::MODE_ROT_CCW:
            begin
                src_row = out_col_reg;
                src_col = w_m1 - out_row_reg;
            end
            iot_pkg::MODE_ROT_180:
            begin
                src_row = h_m1 - out_row_reg;
                src_col = w_m1 - out_col_reg;
            end
            default:
            begin
                src_row = out_row_reg;
                src_col = out_col_reg;
            end
        endcase
    end

    assign load_last_col = (load_col_reg == w_m1);
    assign load_last     = load_last_col && (load_row_reg == h_m1);

    // Classify the accepted word and build the command
    always_comb
    begin
        cmd.kind      = req_type;
        cmd.pixel     = {in_red, in_green, in_blue};
        cmd.row       = (req_type == iot_pkg::REQ_LOAD) ? load_row_reg : src_row;
        cmd.col       = (req_type == iot_pkg::REQ_LOAD) ? load_col_reg : src_col;
        cmd.negate    = (mode_reg == iot_pkg::MODE_NEGATE);
        cmd.row_end   = rend;
        cmd.frame_end = fend;
        cmd_push      = accept && ((req_type == iot_pkg::REQ_LOAD) || ready_reg);
    end

    // Update counters and registers
    always_comb
    begin
        mode_next     = mode_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        ready_next    = ready_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        if (accept)
        begin
            if (req_type == iot_pkg::REQ_LOAD)
            begin
                if (load_last)
                begin
                    load_row_next = '0;
                    load_col_next = '0;
                    ready_next    = 1'b1;
                end
                else
                begin
                    ready_next = 1'b0;
                    if (load_last_col)
                    begin
                        load_row_next = load_row_reg + 1'b1;
                        load_col_next = '0;
                    end
                    else
                    begin
                        load_col_next = load_col_reg + 1'b1;
                    end
                end
            end
            else if (ready_reg)
            begin
                if (fend)
                begin
                    out_row_next = '0;
                    out_col_next = '0;
                end
                else if (rend)
                begin
                    out_row_next = out_row_reg + 1'b1;
                    out_col_next = '0;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx) inside
                iot_pkg::REG_MODE:
                begin
                    mode_next    = pwdata[iot_pkg::MODE_W-1:0];
                    out_row_next = '0;
                    out_col_next = '0;
                end
                iot_pkg::REG_WIDTH, iot_pkg::REG_HEIGHT:
                begin
                    if (cfg_idx == iot_pkg::REG_WIDTH)
                    begin
                        width_next = clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH);
                    end
                    else
                    begin
                        height_next = clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT);
                    end
                    out_row_next  = '0;
                    out_col_next  = '0;
                    load_row_next = '0;
                    load_col_next = '0;
                    ready_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= iot_pkg::MODE_NEGATE;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            load_row_reg <= '0;
            load_col_reg <= '0;
            ready_reg    <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            ready_reg    <= ready_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
        end
    end

endmodule

// File: rtl/core/iot_back.sv
module iot_back #(
    parameter int MAX_WIDTH  = iot_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iot_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [iot_pkg::DIM_W-1:0]   width,
    input  logic                        cmd_empty,
    input  iot_pkg::cmd_t               cmd_head,
    output logic                        cmd_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [iot_pkg::CHAN_W-1:0]  out_blue,
    output logic [iot_pkg::CHAN_W-1:0]  out_green,
    output logic [iot_pkg::CHAN_W-1:0]  out_red,
    output logic                        row_end,
    output logic                        frame_end
);

    localparam int DIM_W     = iot_pkg::DIM_W;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCNT_W    = $clog2(iot_pkg::OUT_DEPTH + 1);
    localparam int CREDIT_W  = OCNT_W + 1;
    localparam int RES_W     = $bits(iot_pkg::res_t);

    logic [iot_pkg::PIX_W-1:0] pixel_mem [DEPTH];

    logic                       s1_valid_reg;
    logic                       s1_read_reg;
    logic [PROD_W-1:0]          s1_prod_reg;
    logic [DIM_W-1:0]           s1_col_reg;
    logic [iot_pkg::PIX_W-1:0]  s1_pixel_reg;
    logic                       s1_neg_reg;
    logic                       s1_rend_reg;
    logic                       s1_fend_reg;
    logic                       s2_valid_reg;
    logic                       s2_neg_reg;
    logic                       s2_rend_reg;
    logic                       s2_fend_reg;
    logic [iot_pkg::PIX_W-1:0]  rd_data_reg;

    logic [OCNT_W-1:0]          out_count;
    logic [CREDIT_W-1:0]        in_flight;
    logic                       credit_ok;
    logic [PROD_W:0]            addr_sum;
    logic [ADDR_W-1:0]          addr;
    iot_pkg::res_t              res_in;
    iot_pkg::res_t              res_out;
    logic [RES_W-1:0]           res_out_bits;

    // Reserve result space for every read still in the pipe
    assign in_flight = CREDIT_W'(out_count) + CREDIT_W'(s1_valid_reg && s1_read_reg)
                     + CREDIT_W'(s2_valid_reg);
    assign credit_ok = (in_flight < CREDIT_W'(iot_pkg::OUT_DEPTH));
    assign cmd_pop   = !cmd_empty && ((cmd_head.kind == iot_pkg::REQ_LOAD) || credit_ok);

    // Stage 1 control: row times width product on its way to the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_pop;
            s2_valid_reg <= s1_valid_reg && s1_read_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_read_reg  <= (cmd_head.kind == iot_pkg::REQ_READ);
        s1_prod_reg  <= PROD_W'(cmd_head.row) * PROD_W'(width);
        s1_col_reg   <= cmd_head.col;
        s1_pixel_reg <= cmd_head.pixel;
        s1_neg_reg   <= cmd_head.negate;
        s1_rend_reg  <= cmd_head.row_end;
        s1_fend_reg  <= cmd_head.frame_end;
        s2_neg_reg   <= s1_neg_reg;
        s2_rend_reg  <= s1_rend_reg;
        s2_fend_reg  <= s1_fend_reg;
    end

    // Stage 2: one store access, write for a load, registered read otherwise
    assign addr_sum = {1'b0, s1_prod_reg} + (PROD_W + 1)'(s1_col_reg);
    assign addr     = ADDR_W'(addr_sum);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !s1_read_reg)
        begin
            pixel_mem[addr] <= s1_pixel_reg;
        end
        if (s1_valid_reg && s1_read_reg)
        begin
            rd_data_reg <= pixel_mem[addr];
        end
    end

    // Apply the negative and queue the result word
    always_comb
    begin
        res_in.pixel     = s2_neg_reg ? ~rd_data_reg : rd_data_reg;
        res_in.row_end   = s2_rend_reg;
        res_in.frame_end = s2_fend_reg;
    end

    iot_queue #(
        .WIDTH (RES_W),
        .DEPTH (iot_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (res_in),
        .full      (),
        .pop       (pop),
        .pop_data  (res_out_bits),
        .empty     (empty),
        .count     (out_count)
    );

    assign res_out   = res_out_bits;
    assign out_blue  = res_out.pixel[iot_pkg::CHAN_W-1:0];
    assign out_green = res_out.pixel[2*iot_pkg::CHAN_W-1:iot_pkg::CHAN_W];
    assign out_red   = res_out.pixel[3*iot_pkg::CHAN_W-1:2*iot_pkg::CHAN_W];
    assign row_end   = res_out.row_end;
    assign frame_end = res_out.frame_end;

endmodule

// File: rtl/core/image_orientation_transform.sv
// Frame store that mirrors, flips, rotates or negates 24-bit pixels.
// Input queue port (push/full): req_type 0 loads the next pixel of the input
// frame in row-major order, req_type 1 asks for the next pixel of the
// transformed frame. Result queue port (empty/pop): one word per served read
// with out_blue/out_green/out_red and the row_end and frame_end marks.
// Reads are served only after a whole frame of width x height pixels has been
// loaded; earlier reads are taken and dropped. Loads give no result.
// Mode, frame_width and frame_height sit at APB byte addresses 0, 4 and 8;
// write them only while the block is idle. A mode write restarts the output
// position, a size write also restarts loading.
// A read word passes the command queue, stage 1, the store read register and
// the result queue. Throughput: one word per cycle, loads and reads alike,
// while full is low, set by the single store port: one write or read per cycle.
// Reset: load and output positions go to zero, no frame is ready, store
// contents are unknown; mode 0 and 256 x 256 (limited to the maximum size).
// Receiver stall: up to 4 results wait in the result queue, the back end then
// halts and the 4-entry command queue fills, after which full rises.
module image_orientation_transform #(
    parameter int MAX_WIDTH  = iot_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iot_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iot_pkg::PADDR_W-1:0]   paddr,
    input  logic [iot_pkg::PDATA_W-1:0]   pwdata,
    output logic [iot_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic                          req_type,
    input  logic [iot_pkg::CHAN_W-1:0]    in_blue,
    input  logic [iot_pkg::CHAN_W-1:0]    in_green,
    input  logic [iot_pkg::CHAN_W-1:0]    in_red,
    output logic                          empty,
    input  logic                          pop,
    output logic [iot_pkg::CHAN_W-1:0]    out_blue,
    output logic [iot_pkg::CHAN_W-1:0]    out_green,
    output logic [iot_pkg::CHAN_W-1:0]    out_red,
    output logic                          row_end,
    output logic                          frame_end
);

    localparam int CMD_W = $bits(iot_pkg::cmd_t);

    logic                       accept;
    logic                       cmd_push;
    iot_pkg::cmd_t              cmd;
    iot_pkg::cmd_t              cmd_head;
    logic [CMD_W-1:0]           cmd_head_bits;
    logic                       cmd_pop;
    logic                       cmd_empty;
    logic [iot_pkg::DIM_W-1:0]  width;

    assign pready   = 1'b1;
    assign accept   = push && !full;
    assign cmd_head = cmd_head_bits;

    // Front end: registers, positions, classification
    iot_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .accept   (accept),
        .req_type (req_type),
        .in_blue  (in_blue),
        .in_green (in_green),
        .in_red   (in_red),
        .cmd_push (cmd_push),
        .cmd      (cmd),
        .width    (width)
    );

    // Command queue between front and back
    iot_queue #(
        .WIDTH (CMD_W),
        .DEPTH (iot_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (cmd_head_bits),
        .empty     (cmd_empty),
        .count     ()
    );

    // Back end: address, store access, result queue
    iot_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (width),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    // Every accepted load reaches the command queue
    a_load_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == iot_pkg::REQ_LOAD)) |-> cmd_push)
        else $error("accepted load not forwarded");

    // The front end never pushes into a full command queue
    a_no_cmd_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !full)
        else $error("command pushed while queue full");

    // A frame end word also closes its row
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> row_end)
        else $error("frame end without row end");

    // A popped command leaves the queue non-empty before the pop
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

endmodule

// File: bench/orient_check_pkg.sv
package orient_check_pkg;
    import iot_pkg::*;

    localparam int STORE_WORDS  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              row_end;
        logic              frame_end;
    } out_pixel_t;

    class orientation_scoreboard;
        logic [PIX_W-1:0]  frame_mem [STORE_WORDS];
        int unsigned       load_idx;
        int unsigned       row_pos;
        int unsigned       col_pos;
        int unsigned       frame_w;
        int unsigned       frame_h;
        logic [MODE_W-1:0] mode;
        bit                frame_ready;
        out_pixel_t        expected_pixels[$];
        int                failures;

        function new();
            load_idx    = 0;
            row_pos     = 0;
            col_pos     = 0;
            frame_w     = MAX_WIDTH_DEF;
            frame_h     = MAX_HEIGHT_DEF;
            mode        = MODE_NEGATE;
            frame_ready = 1'b0;
            failures    = 0;
        endfunction

        // Zero counts as one, anything past the maximum counts as the maximum
        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx) inside
                REG_MODE:
                begin
                    mode    = value[MODE_W-1:0];
                    row_pos = 0;
                    col_pos = 0;
                end
                REG_WIDTH, REG_HEIGHT:
                begin
                    if (idx == REG_WIDTH)
                        frame_w = clamp_dim(value[DIM_W-1:0], MAX_WIDTH_DEF);
                    else
                        frame_h = clamp_dim(value[DIM_W-1:0], MAX_HEIGHT_DEF);
                    row_pos     = 0;
                    col_pos     = 0;
                    load_idx    = 0;
                    frame_ready = 1'b0;
                end
                default:
                begin
                end
            endcase
        endfunction

        // Store a loaded pixel, or work out the transformed pixel a read returns
        function void note_request(logic kind, logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] g,
                                   logic [CHAN_W-1:0] r);
            int unsigned      total;
            int unsigned      ow;
            int unsigned      oh;
            int unsigned      rr;
            int unsigned      cc;
            int unsigned      sr;
            int unsigned      sc;
            logic [PIX_W-1:0] px;
            out_pixel_t       word;

            total = frame_w * frame_h;
            if (kind == REQ_LOAD)
            begin
                frame_mem[load_idx % STORE_WORDS] = {r, g, b};
                if (load_idx + 1 >= total)
                begin
                    load_idx    = 0;
                    frame_ready = 1'b1;
                end
                else
                begin
                    load_idx++;
                    frame_ready = 1'b0;
                end
                return;
            end

            // Drop reads until a whole frame is in
            if (!frame_ready)
                return;

            if (mode == MODE_ROT_CW || mode == MODE_ROT_CCW)
            begin
                ow = frame_h;
                oh = frame_w;
            end
            else
            begin
                ow = frame_w;
                oh = frame_h;
            end
            rr = (row_pos >= oh) ? oh - 1 : row_pos;
            cc = (col_pos >= ow) ? ow - 1 : col_pos;

            case (mode)
                MODE_MIRROR_H:
                begin
                    sr = rr;
                    sc = frame_w - 1 - cc;
                end
                MODE_FLIP_V:
                begin
                    sr = frame_h - 1 - rr;
                    sc = cc;
                end
                MODE_ROT_CW:
                begin
                    sr = frame_h - 1 - cc;
                    sc = rr;
                end
                MODE_ROT_CCW:
                begin
                    sr = cc;
                    sc = frame_w - 1 - rr;
                end
                MODE_ROT_180:
                begin
                    sr = frame_h - 1 - rr;
                    sc = frame_w - 1 - cc;
                end
                default:
                begin
                    sr = rr;
                    sc = cc;
                end
            endcase

            px = frame_mem[(sr * frame_w + sc) % STORE_WORDS];
            if (mode == MODE_NEGATE)
                px = ~px;

            word.blue      = px[CHAN_W-1:0];
            word.green     = px[2*CHAN_W-1:CHAN_W];
            word.red       = px[3*CHAN_W-1:2*CHAN_W];
            word.row_end   = (cc + 1 >= ow);
            word.frame_end = word.row_end && (rr + 1 >= oh);

            // Advance the output position, wrap at frame end
            if (word.frame_end)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            else if (word.row_end)
            begin
                row_pos = rr + 1;
                col_pos = 0;
            end
            else
            begin
                row_pos = rr;
                col_pos = cc + 1;
            end
            expected_pixels.push_back(word);
        endfunction

        function void check_pixel(out_pixel_t got);
            out_pixel_t want;

            if (expected_pixels.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected pixel: b=%h g=%h r=%h row_end=%b frame_end=%b",
                             got.blue, got.green, got.red, got.row_end, got.frame_end);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
                got.row_end !== want.row_end || got.frame_end !== want.frame_end)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"pixel mismatch: expected b=%h g=%h r=%h re=%b fe=%b,",
                              " got b=%h g=%h r=%h re=%b fe=%b"},
                             want.blue, want.green, want.red, want.row_end, want.frame_end,
                             got.blue, got.green, got.red, got.row_end, got.frame_end);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

endpackage

// File: bench/testbench.sv
module testbench;
    import iot_pkg::*;
    import orient_check_pkg::*;

    localparam int STALL_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int SMALL_ITEMS    = 240;
    localparam int MAX_GAP        = 6;

    // Mode codes the block leaves unused: pixels pass through
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               push      = 1'b0;
    logic               full;
    logic               req_type  = REQ_LOAD;
    logic [CHAN_W-1:0]  in_blue   = '0;
    logic [CHAN_W-1:0]  in_green  = '0;
    logic [CHAN_W-1:0]  in_red    = '0;
    logic               empty;
    logic               pop       = 1'b0;
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_red;
    logic               row_end;
    logic               frame_end;

    orientation_scoreboard board;
    bit                    steady       = 1'b0;
    bit                    hold_results = 1'b0;
    int                    item_count   = 0;
    int                    idle_count   = 0;

    image_orientation_transform dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable))
            idle_count <= 0;
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_request(input logic kind, input logic [CHAN_W-1:0] b,
                                input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] r);
        int gap;

        gap = draw_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        req_type <= kind;
        in_blue  <= b;
        in_green <= g;
        in_red   <= r;
        do @(posedge clk); while (full);
        board.note_request(kind, b, g, r);
        item_count++;
    endtask

    task automatic load_random();
        send_request(REQ_LOAD, CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                     CHAN_W'($urandom_range(0, 255)));
    endtask

    // Channels are don't-care on a read; toggle them anyway
    task automatic read_pixels(input int n);
        repeat (n)
            send_request(REQ_READ, CHAN_W'($urandom_range(0, 255)),
                         CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)));
    endtask

    // Fill the whole frame, with stray reads mixed in when asked
    task automatic load_frame(input bit noisy);
        int unsigned total;

        total = board.frame_w * board.frame_h;
        repeat (total)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                read_pixels(1);
            load_random();
        end
    endtask

    // Stop offering and wait for every expected word plus the pipeline tail
    task automatic drain_results();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_register(idx, value);
    endtask

    // One small frame: size, mode, load, read, and sometimes a broken reload
    task automatic run_small_frame(input int idx);
        int unsigned w;
        int unsigned h;
        int unsigned total;

        w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
        h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
        steady = ($urandom_range(0, 3) == 0);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MODE, idx % 8);
        load_frame(1'b1);
        total = board.frame_w * board.frame_h;
        read_pixels(total + $urandom_range(0, total + 2));
        if ($urandom_range(0, 1) == 1)
        begin
            write_reg(REG_MODE, $urandom_range(0, 7));
            read_pixels(total);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, total)) load_random();
            read_pixels($urandom_range(1, 4));
        end
        steady = 1'b0;
    endtask

    // Result side: random pops, one long hold-off on request
    initial
    begin
        int         gap;
        out_pixel_t got;

        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (hold_results)
            begin
                pop <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.blue      = out_blue;
            got.green     = out_green;
            got.red       = out_red;
            got.row_end   = row_end;
            got.frame_end = frame_end;
            board.check_pixel(got);
        end
    end

    initial
    begin
        int start_count;
        int phase;

        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads before any frame is loaded are dropped
        send_request(REQ_READ, 8'h00, 8'h00, 8'h00);
        send_request(REQ_READ, 8'hff, 8'hff, 8'hff);
        send_request(REQ_LOAD, 8'hff, 8'h00, 8'h5a);

        // 3x2 frame with channel extremes, negated, read past frame end
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        write_reg(REG_MODE, MODE_NEGATE);
        send_request(REQ_LOAD, 8'h00, 8'h00, 8'h00);
        send_request(REQ_LOAD, 8'hff, 8'hff, 8'hff);
        send_request(REQ_LOAD, 8'hff, 8'h00, 8'h00);
        send_request(REQ_LOAD, 8'h00, 8'hff, 8'h00);
        send_request(REQ_LOAD, 8'h00, 8'h00, 8'hff);
        send_request(REQ_LOAD, 8'h81, 8'h42, 8'h24);
        read_pixels(7);
        write_reg(REG_MODE, MODE_ROT_CW);
        read_pixels(6);
        write_reg(REG_MODE, MODE_SPARE_7);
        read_pixels(2);

        // Widest frame, width written above range; receiver stalls long
        write_reg(REG_WIDTH, 511);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_MODE, MODE_MIRROR_H);
        load_frame(1'b0);
        steady       = 1'b1;
        hold_results = 1'b1;
        read_pixels(30);
        steady = 1'b0;
        write_reg(REG_MODE, MODE_ROT_CW);
        read_pixels(20);
        write_reg(REG_MODE, MODE_ROT_180);
        read_pixels(20);

        // Many small frames, every mode in turn
        start_count = item_count;
        phase = 0;
        while (item_count - start_count < SMALL_ITEMS)
        begin
            run_small_frame(phase);
            phase++;
        end

        // Narrow frame, zero width counts as one column
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 5);
        write_reg(REG_MODE, MODE_ROT_CCW);
        load_frame(1'b1);
        read_pixels(20);
        write_reg(REG_MODE, MODE_FLIP_V);
        read_pixels(20);
        write_reg(REG_MODE, MODE_SPARE_6);
        read_pixels(10);

        drain_results();
        if (board.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
